>>> sv/framed_command_recognizer_heartbeat_macros.svh
// Assertion macros used by the checker of the command recognizer.
`ifndef FRAMED_COMMAND_RECOGNIZER_HEARTBEAT_MACROS_SVH
`define FRAMED_COMMAND_RECOGNIZER_HEARTBEAT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FCRH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcrh assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FCRH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcrh assertion failed");

`endif

>>> sv/fcrh_pkg.sv
// Types and constants of the framed command recognizer.
`default_nettype none

package fcrh_pkg;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ONLINE,
        CMD_WATER,
        CMD_SOAP,
        CMD_BLOWER,
        CMD_FAUCET,
        CMD_PAUSE,
        CMD_UNRECOGNIZED
    } cmd_code_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        cmd_code_t command_code;
        logic      frame_dropped;
        logic      link_online;
        logic      link_changed;
    } out_item_t;

    // parser -> link and output stage
    typedef struct packed {
        cmd_code_t code;
        logic      dropped;
        logic      online_hit;
    } parse_result_t;

    // link -> output stage
    typedef struct packed {
        logic online;
        logic changed;
    } link_status_t;

    localparam int unsigned KW_COUNT = 6;
    localparam logic [KW_COUNT-1:0] LIVE_ALL = '1;

    localparam logic [7:0] CHAR_OPEN  = 8'h3C;  // '<'
    localparam logic [7:0] CHAR_CLOSE = 8'h3E;  // '>'
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [15:0] TIMEOUT_RESET = 16'd15000;

    // common leading text of the five station keywords
    localparam logic [63:0] KW_PREFIX = "PHYSICAL";

    // keyword text, right-justified: last character sits in byte 0
    localparam logic [127:0] KW_TEXT [KW_COUNT] = '{
        128'("ONLINE"),
        128'({KW_PREFIX, "_WATER"}),
        128'({KW_PREFIX, "_SOAP"}),
        128'({KW_PREFIX, "_BLOWER"}),
        128'({KW_PREFIX, "_FAUCET"}),
        128'({KW_PREFIX, "_PAUSE"})
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd6, 8'd14, 8'd13, 8'd15, 8'd15, 8'd14
    };
    localparam logic [3:0] KW_LAST [KW_COUNT] = '{
        4'd5, 4'd13, 4'd12, 4'd14, 4'd14, 4'd13
    };

endpackage

`default_nettype wire

>>> sv/fcrh_parser.sv
// Frame parser: frame tracking, per-keyword live bits and command decode.
`default_nettype none

module fcrh_parser #(
    parameter int unsigned FRAME_CAPACITY = 64
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire fcrh_pkg::in_item_t      item,
    output fcrh_pkg::parse_result_t      result
);

    localparam int unsigned LEN_W = $clog2(FRAME_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(FRAME_CAPACITY - 1);

    logic                             in_frame_reg, in_frame_next;
    logic [LEN_W-1:0]                 frame_length_reg, frame_length_next;
    logic [fcrh_pkg::KW_COUNT-1:0]    keyword_live_reg, keyword_live_next;
    logic [fcrh_pkg::KW_COUNT-1:0]    keep;
    logic [7:0]                       len8;

    assign len8 = 8'(frame_length_reg);

    // does keyword k still match with rx_byte at the current position
    always_comb
    begin
        for (int k = 0; k < fcrh_pkg::KW_COUNT; k++)
        begin
            keep[k] = (len8 < fcrh_pkg::KW_LEN[k]) &&
                      (fcrh_pkg::KW_TEXT[k][{fcrh_pkg::KW_LAST[k] - frame_length_reg[3:0],
                                             3'b000} +: 8] == item.rx_byte);
        end
    end

    always_comb
    begin
        in_frame_next     = in_frame_reg;
        frame_length_next = frame_length_reg;
        keyword_live_next = keyword_live_reg;
        result.code       = fcrh_pkg::CMD_NONE;
        result.dropped    = 1'b0;
        result.online_hit = 1'b0;

        if (accept && !item.mode)
        begin
            if (item.rx_byte == fcrh_pkg::CHAR_OPEN)
            begin
                in_frame_next     = 1'b1;
                frame_length_next = '0;
                keyword_live_next = fcrh_pkg::LIVE_ALL;
            end
            else if (!in_frame_reg)
            begin
                // outside a frame
            end
            else if (item.rx_byte == fcrh_pkg::CHAR_CLOSE)
            begin
                if (frame_length_reg != '0)
                begin
                    result.code = fcrh_pkg::CMD_UNRECOGNIZED;
                    // descending so the lowest matching keyword wins
                    for (int k = fcrh_pkg::KW_COUNT - 1; k >= 0; k--)
                    begin
                        if (keyword_live_reg[k] && (len8 == fcrh_pkg::KW_LEN[k]))
                        begin
                            result.code = fcrh_pkg::cmd_code_t'(3'(k + 1));
                        end
                    end
                    result.online_hit = (result.code == fcrh_pkg::CMD_ONLINE);
                end
                in_frame_next     = 1'b0;
                frame_length_next = '0;
                keyword_live_next = fcrh_pkg::LIVE_ALL;
            end
            else if (item.rx_byte == fcrh_pkg::CHAR_CR || item.rx_byte == fcrh_pkg::CHAR_LF)
            begin
                // line breaks inside a frame
            end
            else if (frame_length_reg < LEN_LIMIT)
            begin
                keyword_live_next = keyword_live_reg & keep;
                frame_length_next = frame_length_reg + 1'b1;
            end
            else
            begin
                in_frame_next     = 1'b0;
                frame_length_next = '0;
                keyword_live_next = fcrh_pkg::LIVE_ALL;
                result.dropped    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg     <= 1'b0;
            frame_length_reg <= '0;
            keyword_live_reg <= fcrh_pkg::LIVE_ALL;
        end
        else
        begin
            in_frame_reg     <= in_frame_next;
            frame_length_reg <= frame_length_next;
            keyword_live_reg <= keyword_live_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/fcrh_link.sv
// Heartbeat tracker: saturating tick counter and online flag.
`default_nettype none

module fcrh_link (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 tick,
    input  wire logic                 online_hit,
    input  wire logic [15:0]          timeout_ms,
    output fcrh_pkg::link_status_t    status
);

    logic [15:0] elapsed_ticks_reg, elapsed_ticks_next;
    logic        online_reg, online_next;
    logic [15:0] elapsed_inc;

    assign elapsed_inc = (elapsed_ticks_reg != 16'hFFFF) ? elapsed_ticks_reg + 16'd1
                                                         : elapsed_ticks_reg;

    always_comb
    begin
        elapsed_ticks_next = elapsed_ticks_reg;
        online_next        = online_reg;
        if (tick)
        begin
            elapsed_ticks_next = elapsed_inc;
            if (online_reg && (elapsed_inc >= timeout_ms))
            begin
                online_next = 1'b0;
            end
        end
        else if (online_hit)
        begin
            online_next        = 1'b1;
            elapsed_ticks_next = '0;
        end
        status.online  = online_next;
        status.changed = online_next != online_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_ticks_reg <= '0;
            online_reg        <= 1'b0;
        end
        else
        begin
            elapsed_ticks_reg <= elapsed_ticks_next;
            online_reg        <= online_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/framed_command_recognizer_heartbeat.sv
// Top level of the framed command recognizer with heartbeat timeout.
// Input channel (in_valid/in_ready/in_data): one transaction is either a
// received UART byte (mode 0) or a one millisecond tick (mode 1).
// Output channel (out_valid/out_ready/out_data): exactly one result per
// input transaction, in order: command code of a closed frame, oversize
// drop flag, and the link state with a change flag.
// The result is registered: valid in the cycle after the input is accepted.
// Throughput: one transaction per cycle; parser and heartbeat state update
// in the accepting cycle and the result register holds the answer.
// When the receiver stalls, the result register holds and in_ready drops
// until the result is taken; taking it reopens the input in the same cycle.
// cfg_wr_en/cfg_wr_data write timeout_ms at once; write it only while idle.
// Reset (rst_n low, asynchronous): no frame open, all keywords live,
// counter zero, link offline, timeout_ms 15000, output empty.
// FRAME_CAPACITY sets the frame length limit: a frame of FRAME_CAPACITY-1
// characters is dropped on its next character except '<', '>', CR or LF.
`default_nettype none

module framed_command_recognizer_heartbeat #(
    parameter int unsigned FRAME_CAPACITY = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire fcrh_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output fcrh_pkg::out_item_t       out_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [15:0]          cfg_wr_data
);

    logic                     accept;
    logic [15:0]              timeout_reg;
    logic                     out_valid_reg, out_valid_next;
    fcrh_pkg::out_item_t      out_data_reg;
    fcrh_pkg::parse_result_t  parse;
    fcrh_pkg::link_status_t   link;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    fcrh_parser #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .result (parse)
    );

    fcrh_link u_link (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (accept && in_data.mode),
        .online_hit (parse.online_hit),
        .timeout_ms (timeout_reg),
        .status     (link)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            timeout_reg   <= fcrh_pkg::TIMEOUT_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.command_code  <= parse.code;
            out_data_reg.frame_dropped <= parse.dropped;
            out_data_reg.link_online   <= link.online;
            out_data_reg.link_changed  <= link.changed;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> sv/fcrh_checker.sv
// Port-level checker for the command recognizer, bound to the top level.
`default_nettype none

`include "framed_command_recognizer_heartbeat_macros.svh"

module fcrh_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire fcrh_pkg::out_item_t  out_data
);

    // stalled result holds
    `FCRH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // every accepted transaction shows its result on the next cycle
    `FCRH_ASSERT_NEXT(a_result_next, in_valid && in_ready, out_valid)

    // input is closed while a result waits on a stalled receiver
    `FCRH_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready)

    // the link only comes online through an ONLINE frame
    `FCRH_ASSERT_NOW(a_online_cause,
        out_valid && out_data.link_changed && out_data.link_online,
        out_data.command_code == fcrh_pkg::CMD_ONLINE)

    // a drop never comes with a command
    `FCRH_ASSERT_NOW(a_drop_no_cmd,
        out_valid && out_data.frame_dropped,
        out_data.command_code == fcrh_pkg::CMD_NONE && !out_data.link_changed)

endmodule

bind framed_command_recognizer_heartbeat fcrh_checker u_fcrh_checker (.*);

`default_nettype wire
